/* rtl/sbsm_pkg.sv */
// Package for the serial bank switch mapper: beat types, codes and constants.
// Depends on nothing; used by the top level and its checker.
package sbsm_pkg;

  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_PRAM = 3'd1,
    TGT_PROM = 3'd2,
    TGT_CROM = 3'd3,
    TGT_CRAM = 3'd4
  } target_t;

  typedef enum logic [2:0] {
    LD_NONE  = 3'd0,
    LD_CTRL  = 3'd1,
    LD_CHR0  = 3'd2,
    LD_CHR1  = 3'd3,
    LD_PRG   = 3'd4,
    LD_RESET = 3'd5
  } loaded_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A   = 2'd0,
    PRG_MODE_32K_B   = 2'd1,
    PRG_MODE_FIX_LOW = 2'd2,
    PRG_MODE_FIX_TOP = 2'd3
  } prg_mode_t;

  typedef enum logic [1:0] {
    SEL_CTRL = 2'd0,
    SEL_CHR0 = 2'd1,
    SEL_CHR1 = 2'd2,
    SEL_PRG  = 2'd3
  } reg_sel_t;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic        REG_PRG_PAGE = 1'b0;
  localparam logic        REG_CHR_RAM  = 1'b1;

  localparam logic [4:0]  CTRL_RESET     = 5'h1C;
  localparam logic [4:0]  CTRL_MODE3     = 5'h0C;
  localparam logic [4:0]  PRG_PAGES_RST  = 5'd16;
  localparam logic [2:0]  SHIFT_FULL     = 3'd5;
  localparam logic [15:0] PRAM_BASE      = 16'h6000;
  localparam logic [15:0] PROM_BASE      = 16'h8000;
  localparam logic [15:0] CHR_TOP        = 16'h1FFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [17:0] mapped_address;
    logic        write_enable;
    logic [1:0]  mirroring;
    logic [2:0]  register_loaded;
  } out_beat_t;

endpackage

/* rtl/serial_bank_switch_mapper.sv */
// A beat accepted into the input stage passes to the result stage when that stage is free
// or its result is being taken; out_data is driven from the result register.
// Throughput: one beat per cycle unless out_ready stalls; the input stage and
// the result stage each hold one beat, so one more is taken while a result waits.
// Reset (rst_n low, synchronous) empties both stages and restores control,
// loader, bank and configuration registers to their reset values.
// Uses sbsm_pkg for beat types, codes and constants.
module serial_bank_switch_mapper (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sbsm_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sbsm_pkg::out_beat_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbsm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbsm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready
);
  import sbsm_pkg::*;

  logic [4:0] prg_pages_r;
  logic       chr_ram_r;
  logic [4:0] ctrl_r, ctrl_nxt;
  logic [4:0] shift_r, shift_nxt;
  logic [2:0] count_r, count_nxt;
  logic [4:0] chr0_r, chr0_nxt;
  logic [4:0] chr1_r, chr1_nxt;
  logic [4:0] prg_r, prg_nxt;

  logic      stg_valid_r;
  in_beat_t  stg_r;
  logic      out_valid_r;
  out_beat_t out_r, out_nxt;
  logic      advance;

  cmd_t       cmd;
  logic [15:0] a;
  logic [7:0]  d;
  logic [3:0]  sel;
  logic [3:0]  last_page;
  logic [3:0]  page;
  logic [17:0] prg_off;
  logic [17:0] chr_off;
  logic [4:0]  shift_in;
  logic [2:0]  count_inc;
  logic        cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !stg_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PRG_PAGE) begin
      prdata = {{(CFG_DATA_W-5){1'b0}}, prg_pages_r};
    end else begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, chr_ram_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_pages_r <= PRG_PAGES_RST;
      chr_ram_r   <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PRG_PAGE) begin
        prg_pages_r <= pwdata[4:0];
      end else begin
        chr_ram_r <= pwdata[0];
      end
    end
  end

  // Bank arithmetic on the staged beat, using state from before this beat.
  always_comb begin
    cmd       = cmd_t'(stg_r.cmd);
    a         = stg_r.bus_address;
    d         = stg_r.write_data;
    sel       = prg_r[3:0];
    last_page = 4'(prg_pages_r - 5'd1);
    page      = '0;
    prg_off   = '0;
    case (prg_mode_t'(ctrl_r[3:2]))
      PRG_MODE_FIX_LOW: page = a[14] ? sel : 4'd0;
      PRG_MODE_FIX_TOP: page = a[14] ? last_page : sel;
      default:          page = '0;
    endcase
    if (ctrl_r[3] == 1'b0) begin
      prg_off = {sel[3:1], a[14:0]};
    end else begin
      prg_off = {page, a[13:0]};
    end
    if (ctrl_r[4] == 1'b0) begin
      chr_off = {1'b0, chr0_r[4:1], a[12:0]};
    end else if (a[12] == 1'b0) begin
      chr_off = {1'b0, chr0_r, a[11:0]};
    end else begin
      chr_off = {1'b0, chr1_r, a[11:0]};
    end
  end

  always_comb begin
    ctrl_nxt  = ctrl_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    chr0_nxt  = chr0_r;
    chr1_nxt  = chr1_r;
    prg_nxt   = prg_r;
    shift_in  = {d[0], shift_r[4:1]};
    count_inc = count_r + 3'd1;
    out_nxt   = '0;

    if (cmd == CMD_CPU_RD || cmd == CMD_CPU_WR) begin
      if (a >= PRAM_BASE && a < PROM_BASE) begin
        out_nxt.target         = TGT_PRAM;
        out_nxt.mapped_address = {5'd0, a[12:0]};
        out_nxt.write_enable   = (cmd == CMD_CPU_WR);
      end else if (a >= PROM_BASE) begin
        if (cmd == CMD_CPU_RD) begin
          out_nxt.target         = TGT_PROM;
          out_nxt.mapped_address = prg_off;
        end else if (d[7]) begin
          ctrl_nxt  = ctrl_r | CTRL_MODE3;
          shift_nxt = '0;
          count_nxt = '0;
          out_nxt.register_loaded = LD_RESET;
        end else if (count_inc < SHIFT_FULL) begin
          shift_nxt = shift_in;
          count_nxt = count_inc;
        end else begin
          shift_nxt = '0;
          count_nxt = '0;
          unique case (reg_sel_t'(a[14:13]))
            SEL_CTRL: begin
              ctrl_nxt = shift_in;
              out_nxt.register_loaded = LD_CTRL;
            end
            SEL_CHR0: begin
              chr0_nxt = shift_in;
              out_nxt.register_loaded = LD_CHR0;
            end
            SEL_CHR1: begin
              chr1_nxt = shift_in;
              out_nxt.register_loaded = LD_CHR1;
            end
            SEL_PRG: begin
              prg_nxt = shift_in;
              out_nxt.register_loaded = LD_PRG;
            end
          endcase
        end
      end
    end else if (a <= CHR_TOP) begin
      out_nxt.target         = chr_ram_r ? TGT_CRAM : TGT_CROM;
      out_nxt.mapped_address = chr_off;
      out_nxt.write_enable   = (cmd == CMD_PPU_WR) && chr_ram_r;
    end
    out_nxt.mirroring = ctrl_nxt[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= CTRL_RESET;
      shift_r     <= '0;
      count_r     <= '0;
      chr0_r      <= '0;
      chr1_r      <= '0;
      prg_r       <= '0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= stg_valid_r;
      end
      if (advance && stg_valid_r) begin
        ctrl_r  <= ctrl_nxt;
        shift_r <= shift_nxt;
        count_r <= count_nxt;
        chr0_r  <= chr0_nxt;
        chr1_r  <= chr1_nxt;
        prg_r   <= prg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_r <= in_data;
    end
    if (advance && stg_valid_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/sbsm_checker.sv */
// Port-level checker for the serial bank switch mapper, with its bind.
// Depends on sbsm_pkg and on the top level's ports.
module sbsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sbsm_pkg::out_beat_t out_data
);
  import sbsm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target == TGT_NONE |->
      out_data.mapped_address == '0 && !out_data.write_enable)
    else $error("Unmapped beat carries an address or a write enable.");

  a_load_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.register_loaded != LD_NONE |-> out_data.target == TGT_NONE)
    else $error("Register load reported on a memory access.");

  a_we_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_enable |->
      out_data.target == TGT_PRAM || out_data.target == TGT_CRAM)
    else $error("Write enable on a read-only target.");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid straight after reset.");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/serial_bank_switch_mapper_checker.sv */
`timescale 1ns / 1ps
// Checker for the serial bank switch mapper: mirrors the mapper and loader state, predicts
// each result beat and compares it field by field. Depends on sbsm_pkg for beat types.
module serial_bank_switch_mapper_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sbsm_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sbsm_pkg::out_beat_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbsm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  input  logic                            end_check,
  output int                              maps_outstanding,
  output int                              fail_count
);
  import sbsm_pkg::*;

  logic [4:0] ctrl_q;
  logic [4:0] shift_q;
  logic [2:0] shift_cnt_q;
  logic [4:0] chr_lo_q;
  logic [4:0] chr_hi_q;
  logic [4:0] prg_bank_q;
  logic [4:0] page_cnt_q;
  logic       chr_ram_q;
  out_beat_t  expected_maps[$];
  out_beat_t  want;
  logic       drain_checked = 1'b0;

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mapper mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [17:0] prg_rom_offset(input logic [15:0] a);
    logic [3:0] sel;
    logic [3:0] last;
    logic [3:0] page;
    sel  = prg_bank_q[3:0];
    last = 4'(page_cnt_q - 5'd1);
    case (prg_mode_t'(ctrl_q[3:2]))
      PRG_MODE_32K_A, PRG_MODE_32K_B: return {sel[3:1], a[14:0]};
      PRG_MODE_FIX_LOW: page = a[14] ? sel : 4'd0;
      default: page = a[14] ? last : sel;
    endcase
    return {page, a[13:0]};
  endfunction

  function automatic logic [17:0] chr_offset_of(input logic [15:0] a);
    if (!ctrl_q[4]) return {1'b0, chr_lo_q[4:1], a[12:0]};
    if (!a[12]) return {1'b0, chr_lo_q, a[11:0]};
    return {1'b0, chr_hi_q, a[11:0]};
  endfunction

  function automatic loaded_t shift_in_write(input logic [15:0] a, input logic [7:0] d);
    logic [4:0] value;
    loaded_t    ld;
    ld = LD_NONE;
    if (d[7]) begin
      ctrl_q      = ctrl_q | CTRL_MODE3;
      shift_q     = '0;
      shift_cnt_q = '0;
      ld          = LD_RESET;
    end else begin
      shift_q     = {d[0], shift_q[4:1]};
      shift_cnt_q = shift_cnt_q + 3'd1;
      if (shift_cnt_q >= SHIFT_FULL) begin
        value       = shift_q;
        shift_q     = '0;
        shift_cnt_q = '0;
        case (reg_sel_t'(a[14:13]))
          SEL_CTRL: begin
            ctrl_q = value;
            ld     = LD_CTRL;
          end
          SEL_CHR0: begin
            chr_lo_q = value;
            ld       = LD_CHR0;
          end
          SEL_CHR1: begin
            chr_hi_q = value;
            ld       = LD_CHR1;
          end
          default: begin
            prg_bank_q = value;
            ld         = LD_PRG;
          end
        endcase
      end
    end
    return ld;
  endfunction

  function automatic out_beat_t predict_mapping(input in_beat_t b);
    out_beat_t r;
    cmd_t      cmd;
    r                 = '0;
    r.target          = TGT_NONE;
    r.register_loaded = LD_NONE;
    cmd               = cmd_t'(b.cmd);
    if (cmd == CMD_CPU_RD || cmd == CMD_CPU_WR) begin
      if (b.bus_address >= PRAM_BASE && b.bus_address < PROM_BASE) begin
        r.target         = TGT_PRAM;
        r.mapped_address = 18'(b.bus_address[12:0]);
        r.write_enable   = (cmd == CMD_CPU_WR);
      end else if (b.bus_address >= PROM_BASE) begin
        if (cmd == CMD_CPU_RD) begin
          r.target         = TGT_PROM;
          r.mapped_address = prg_rom_offset(b.bus_address);
        end else begin
          r.register_loaded = shift_in_write(b.bus_address, b.write_data);
        end
      end
    end else if (b.bus_address <= CHR_TOP) begin
      r.target         = chr_ram_q ? TGT_CRAM : TGT_CROM;
      r.mapped_address = chr_offset_of(b.bus_address);
      r.write_enable   = (cmd == CMD_PPU_WR) && chr_ram_q;
    end
    r.mirroring = ctrl_q[1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ctrl_q      = CTRL_RESET;
      shift_q     = '0;
      shift_cnt_q = '0;
      chr_lo_q    = '0;
      chr_hi_q    = '0;
      prg_bank_q  = '0;
      page_cnt_q  = PRG_PAGES_RST;
      chr_ram_q   = 1'b0;
      expected_maps.delete();
      maps_outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_PRG_PAGE, 2'b00}) page_cnt_q = pwdata[4:0];
        else if (paddr == {REG_CHR_RAM, 2'b00}) chr_ram_q = pwdata[0];
      end
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no access outstanding", out_data));
        end else begin
          want = expected_maps.pop_front();
          if (out_data.target !== want.target)
            report_mismatch($sformatf("target got %0d, expected %0d",
                                      out_data.target, want.target));
          if (out_data.mapped_address !== want.mapped_address)
            report_mismatch($sformatf("mapped_address got %h, expected %h",
                                      out_data.mapped_address, want.mapped_address));
          if (out_data.write_enable !== want.write_enable)
            report_mismatch($sformatf("write_enable got %b, expected %b",
                                      out_data.write_enable, want.write_enable));
          if (out_data.mirroring !== want.mirroring)
            report_mismatch($sformatf("mirroring got %0d, expected %0d",
                                      out_data.mirroring, want.mirroring));
          if (out_data.register_loaded !== want.register_loaded)
            report_mismatch($sformatf("register_loaded got %0d, expected %0d",
                                      out_data.register_loaded, want.register_loaded));
        end
      end
      if (in_valid && in_ready) expected_maps.push_back(predict_mapping(in_data));
      maps_outstanding <= expected_maps.size();
    end
    if (end_check && !drain_checked) begin
      drain_checked = 1'b1;
      if (expected_maps.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", expected_maps.size()));
    end
  end

endmodule

/* tb/serial_bank_switch_mapper_tb.sv */
`timescale 1ns / 1ps
// Top of the serial bank switch mapper testbench: clock, reset, access beats, register
// writes and the verdict. Depends on sbsm_pkg, the mapper and its checker.
module serial_bank_switch_mapper_tb;
  import sbsm_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  end_check = 1'b0;
  int                    maps_outstanding;
  int                    fail_count;
  int                    burst_left   = 0;
  int                    beats_sent   = 0;
  int                    idle_cycles  = 0;
  int                    ready_pct    = 100;
  int                    ready_window = 0;

  serial_bank_switch_mapper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  serial_bank_switch_mapper_checker mapping_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .end_check        (end_check),
    .maps_outstanding (maps_outstanding),
    .fail_count       (fail_count)
  );

  always #5 clk = ~clk;

  // The receiver switches between stall densities from one random window to the next.
  always @(posedge clk) begin
    if (ready_window == 0) begin
      ready_window = $urandom_range(80, 16);
      case ($urandom_range(3, 0))
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 40;
        default: ready_pct = 15;
      endcase
    end
    ready_window--;
    out_ready <= ($urandom_range(99, 0) < ready_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("serial_bank_switch_mapper_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(8, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_access(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
    in_beat_t b;
    b.cmd         = c;
    b.bus_address = a;
    b.write_data  = d;
    send_beat(b);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (maps_outstanding != 0);
  endtask

  function automatic in_beat_t rand_access();
    in_beat_t b;
    b.cmd = 2'($urandom);
    case ($urandom_range(5, 0))
      0: b.bus_address = 16'($urandom_range(16'h1FFF, 0));
      1: b.bus_address = 16'($urandom_range(16'h5FFF, 16'h2000));
      2: b.bus_address = 16'($urandom_range(16'h7FFF, 16'h6000));
      3: begin
        case ($urandom_range(9, 0))
          0: b.bus_address = 16'h0000;
          1: b.bus_address = 16'h1FFF;
          2: b.bus_address = 16'h2000;
          3: b.bus_address = 16'h5FFF;
          4: b.bus_address = 16'h6000;
          5: b.bus_address = 16'h7FFF;
          6: b.bus_address = 16'h8000;
          7: b.bus_address = 16'hBFFF;
          8: b.bus_address = 16'hC000;
          default: b.bus_address = 16'hFFFF;
        endcase
      end
      default: b.bus_address = 16'($urandom);
    endcase
    b.write_data = 8'($urandom);
    return b;
  endfunction

  // Any access that leaves the serial loader alone.
  function automatic in_beat_t quiet_access();
    in_beat_t b;
    b = rand_access();
    if (cmd_t'(b.cmd) == CMD_CPU_WR && b.bus_address[15]) b.cmd = CMD_CPU_RD;
    return b;
  endfunction

  task automatic load_reg(input reg_sel_t sel, input logic [4:0] value, input int nbits);
    in_beat_t b;
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(3, 0) == 0) send_beat(quiet_access());
      b.cmd         = CMD_CPU_WR;
      b.bus_address = {1'b1, sel, 13'($urandom)};
      b.write_data  = {1'b0, 6'($urandom), value[i]};
      send_beat(b);
    end
  endtask

  task automatic run_random(input int stop_at);
    int kind;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(9, 0);
      if (kind < 4) begin
        load_reg(reg_sel_t'($urandom_range(3, 0)), 5'($urandom), 5);
      end else if (kind == 4) begin
        // An interrupted load, mostly followed by a loader reset.
        load_reg(reg_sel_t'($urandom_range(3, 0)), 5'($urandom), $urandom_range(4, 1));
        if ($urandom_range(3, 0) != 0)
          send_access(CMD_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
      end else begin
        send_beat(rand_access());
      end
    end
  endtask

  initial begin
    int   pages;
    logic chr_ram;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write({REG_PRG_PAGE, 2'b00}, 32'd16);
    cfg_write({REG_CHR_RAM, 2'b00}, 32'd0);

    send_access(CMD_CPU_RD, 16'h0000, 8'hFF);
    send_access(CMD_CPU_WR, 16'h5FFF, 8'h00);
    send_access(CMD_CPU_RD, 16'h6000, 8'h00);
    send_access(CMD_CPU_WR, 16'h7FFF, 8'hAA);
    send_access(CMD_CPU_RD, 16'h8000, 8'h55);
    send_access(CMD_CPU_RD, 16'hFFFF, 8'h00);
    send_access(CMD_PPU_RD, 16'h0000, 8'h00);
    // Writes to character ROM are reported but not enabled.
    send_access(CMD_PPU_WR, 16'h1FFF, 8'hFF);
    send_access(CMD_PPU_RD, 16'h2000, 8'h00);
    send_access(CMD_PPU_WR, 16'hFFFF, 8'h7F);
    send_access(CMD_CPU_WR, 16'h8000, 8'h80);
    // Program bank bit 4 is held but plays no part in the mapping.
    load_reg(SEL_PRG, 5'h1F, 5);
    send_access(CMD_CPU_RD, 16'h8000, 8'h00);
    send_access(CMD_CPU_RD, 16'hC000, 8'h00);
    load_reg(SEL_CTRL, 5'h02, 5);
    send_access(CMD_CPU_RD, 16'hFFFF, 8'h00);
    send_access(CMD_PPU_RD, 16'h1FFF, 8'h00);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin
          pages   = 16;
          chr_ram = 1'b0;
        end
        1: begin
          pages   = 1;
          chr_ram = 1'b1;
        end
        2: begin
          pages   = 0;
          chr_ram = 1'b0;
        end
        3: begin
          pages   = 16;
          chr_ram = 1'b1;
        end
        default: begin
          pages   = $urandom_range(16, 0);
          chr_ram = 1'($urandom);
        end
      endcase
      cfg_write({REG_PRG_PAGE, 2'b00}, 32'(pages));
      cfg_write({REG_CHR_RAM, 2'b00}, 32'(chr_ram));
      run_random(beats_sent + 150);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_bank_switch_mapper_tb: PASS");
    end else begin
      $display("serial_bank_switch_mapper_tb: FAIL");
    end
    $finish;
  end

endmodule
